@@ hdl/sdi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdi_pkg
// Shared types and constants for the strict decimal int32 parser.
// ----------------------------------------------------------------------------
package sdi_pkg;

   localparam int unsigned CHAR_W = 8;
   localparam int unsigned VALUE_W = 32;
   // Magnitude times ten plus a digit needs four extra bits.
   localparam int unsigned WIDE_W = VALUE_W + 4;

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;

   localparam logic [WIDE_W-1:0] POS_LIMIT = 36'd2147483647;
   localparam logic [WIDE_W-1:0] NEG_LIMIT = 36'd2147483648;

   typedef enum logic [2:0] {
      PH_SKIP  = 3'd0,
      PH_SIGN  = 3'd1,
      PH_ZERO  = 3'd2,
      PH_DIGIT = 3'd3,
      PH_ERR   = 3'd4
   } phase_type;

   // Decoded character, passed from the classifier to the parse core.
   typedef struct packed {
      logic       is_term;
      logic       is_space;
      logic       is_minus;
      logic       is_digit;
      logic [3:0] digit;
   } char_class_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      error_flag;
   } result_type;

endpackage : sdi_pkg
`default_nettype wire

@@ hdl/sdi_chan_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdi_req_if / sdi_rsp_if
// Valid/ready channels for character words in and result words out.
// ----------------------------------------------------------------------------
interface sdi_req_if
   import sdi_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface : sdi_req_if

interface sdi_rsp_if
   import sdi_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   logic                      error_flag;

   modport source (output valid, output value, output error_flag, input ready);
   modport sink   (input valid, input value, input error_flag, output ready);
endinterface : sdi_rsp_if
`default_nettype wire

@@ hdl/strict_decimal_int32_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// strict_decimal_int32_parser
// Strict decimal string to signed 32-bit integer, one character per word.
// ----------------------------------------------------------------------------
// Each accepted req word carries one character; a zero byte ends the string
// and produces exactly one rsp word with the parsed value and an error flag
// (value is 0 when the flag is set). Leading whitespace and one '-' are
// allowed; '+', stray characters, missing digits, leading zeros, "-0" and
// int32 overflow are errors. The block takes one character per clock while no
// terminator is held: a character is registered at acceptance and applied to
// the parse state in the next cycle by a single multiply-by-ten-and-add step.
// A terminator is applied only once the output register is free, and the result
// is loaded into that register and shown on rsp. Only a terminator that finds
// that register still full and not being taken holds the input stage;
// ordinary characters keep flowing while rsp is stalled.
// ----------------------------------------------------------------------------
module strict_decimal_int32_parser
   import sdi_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   sdi_req_if.sink   req_chan,
   sdi_rsp_if.source rsp_chan
);

   // input register
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              char_vld_ff, char_vld_in;

   // result register
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                      rsp_err_ff, rsp_err_in;
   logic                      rsp_vld_ff, rsp_vld_in;

   char_class_type cls;
   result_type     result;

   logic out_free;   // result register can take a word this cycle
   logic stage_go;   // registered character is applied this cycle
   logic out_load;   // terminator loads the result register
   logic req_take;

   sdi_char_class u_class (
      .char_code (char_ff),
      .cls       (cls)
   );

   sdi_parse_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (stage_go),
      .cls    (cls),
      .result (result)
   );

   assign out_free = !rsp_vld_ff || rsp_chan.ready;
   assign stage_go = char_vld_ff && (!cls.is_term || out_free);
   assign out_load = stage_go && cls.is_term;

   assign req_chan.ready = !char_vld_ff || stage_go;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      char_in     = req_take ? req_chan.char_code : char_ff;
      char_vld_in = req_take || (char_vld_ff && !stage_go);
   end

   always_comb begin
      rsp_value_in = out_load ? result.value : rsp_value_ff;
      rsp_err_in   = out_load ? result.error_flag : rsp_err_ff;
      rsp_vld_in   = out_load || (rsp_vld_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         char_vld_ff <= char_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      char_ff      <= char_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_chan.valid      = rsp_vld_ff;
   assign rsp_chan.value      = rsp_value_ff;
   assign rsp_chan.error_flag = rsp_err_ff;

`ifndef NO_ASSERTIONS
   a_err_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_err_ff |-> (rsp_value_ff == '0))
      else $error("error result with nonzero value");

   a_load_only_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result register overwritten while held");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_chan.ready |=>
         rsp_vld_ff && $stable(rsp_value_ff) && $stable(rsp_err_ff))
      else $error("result word changed while stalled");
`endif

endmodule : strict_decimal_int32_parser
`default_nettype wire

@@ hdl/sdi_char_class.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdi_char_class
// Decodes one character byte into terminator, space, minus and digit flags.
// ----------------------------------------------------------------------------
module sdi_char_class
   import sdi_pkg::*;
(
   input  wire logic [CHAR_W-1:0] char_code,
   output char_class_type         cls
);

   logic [CHAR_W-1:0] digit_off;

   assign digit_off = char_code - CHAR_ZERO;

   always_comb begin
      cls.is_term  = (char_code == CHAR_NUL);
      cls.is_space = ((char_code >= CHAR_TAB) && (char_code <= CHAR_CR)) ||
                     (char_code == CHAR_SPACE);
      cls.is_minus = (char_code == CHAR_MINUS);
      cls.is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
      cls.digit    = digit_off[3:0];
   end

endmodule : sdi_char_class
`default_nettype wire

@@ hdl/sdi_parse_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdi_parse_core
// Parse state (phase, magnitude, sign) and the result formed at a terminator.
// ----------------------------------------------------------------------------
module sdi_parse_core
   import sdi_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           step,
   input  wire char_class_type cls,
   output result_type          result
);

   phase_type           phase_ff, phase_in;
   logic [VALUE_W-1:0]  mag_ff, mag_in;
   logic                neg_ff, neg_in;

   logic [WIDE_W-1:0]   mag_wide;
   logic [WIDE_W-1:0]   next_wide;
   logic [WIDE_W-1:0]   limit;
   logic [VALUE_W-1:0]  first_mag;
   phase_type           first_phase;

   // magnitude * 10 + digit as (m << 3) + (m << 1) + d
   assign mag_wide  = {4'd0, mag_ff};
   assign next_wide = (mag_wide << 3) + (mag_wide << 1) + {32'd0, cls.digit};
   assign limit     = neg_ff ? NEG_LIMIT : POS_LIMIT;
   assign first_mag = {28'd0, cls.digit};
   assign first_phase = (cls.digit == 4'd0) ? PH_ZERO : PH_DIGIT;

   // Next state
   always_comb begin
      phase_in = phase_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      if (step) begin
         if (cls.is_term) begin
            phase_in = PH_SKIP;
            mag_in   = '0;
            neg_in   = 1'b0;
         end else begin
            unique case (phase_ff)
               PH_SKIP: begin
                  priority if (cls.is_space) begin
                     phase_in = PH_SKIP;
                  end else if (cls.is_minus) begin
                     neg_in   = 1'b1;
                     phase_in = PH_SIGN;
                  end else if (cls.is_digit) begin
                     mag_in   = first_mag;
                     phase_in = first_phase;
                  end else begin
                     phase_in = PH_ERR;
                  end
               end
               PH_SIGN: begin
                  if (cls.is_digit) begin
                     mag_in   = first_mag;
                     phase_in = first_phase;
                  end else begin
                     phase_in = PH_ERR;
                  end
               end
               PH_DIGIT: begin
                  if (!cls.is_digit) begin
                     phase_in = PH_ERR;
                  end else if (next_wide > limit) begin
                     phase_in = PH_ERR;
                     mag_in   = '0;
                  end else begin
                     mag_in = next_wide[VALUE_W-1:0];
                  end
               end
               default: begin
                  // leading zero followed by more text, or already in error
                  phase_in = PH_ERR;
               end
            endcase
         end
      end
   end

   // Outputs: the result as it stands if the current word is a terminator
   always_comb begin
      result.value      = '0;
      result.error_flag = 1'b1;
      if (phase_ff == PH_DIGIT) begin
         result.error_flag = 1'b0;
         result.value      = neg_ff ? $signed(-mag_ff) : $signed(mag_ff);
      end else if ((phase_ff == PH_ZERO) && !neg_ff) begin
         result.error_flag = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SKIP;
         mag_ff   <= '0;
         neg_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         mag_ff   <= mag_in;
         neg_ff   <= neg_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_term_restarts: assert property (@(posedge clock) disable iff (reset)
      step && cls.is_term |=> (phase_ff == PH_SKIP) && (mag_ff == '0) && !neg_ff)
      else $error("parse state not cleared after terminator");

   a_zero_phase_mag: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ZERO) |-> (mag_ff == '0))
      else $error("leading-zero phase with nonzero magnitude");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DIGIT) && !neg_ff |-> !mag_ff[VALUE_W-1])
      else $error("positive magnitude past int32 maximum");
`endif

endmodule : sdi_parse_core
`default_nettype wire
